### design/dur_pkg.sv
// ----------------------------------------------------------------------------
// dur_pkg
// Shared widths, register indexes, reset values and the constants of the
// count to centimeter conversion for the dual ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package dur_pkg;

  localparam int DUR_COUNT_WIDTH = 16;
  localparam int DUR_DIST_W      = 11;
  localparam int DUR_CFG_IDX_W   = 2;
  localparam int DUR_CFG_DATA_W  = 16;

  // register indexes
  localparam logic [DUR_CFG_IDX_W-1:0] DUR_CFG_TICK_US       = 2'd0;
  localparam logic [DUR_CFG_IDX_W-1:0] DUR_CFG_MIN_COUNT     = 2'd1;
  localparam logic [DUR_CFG_IDX_W-1:0] DUR_CFG_TRIGGER_TICKS = 2'd2;

  localparam logic [7:0]  DUR_TICK_US_RST       = 8'd10;
  localparam logic [15:0] DUR_MIN_COUNT_RST     = 16'd10;
  localparam logic [7:0]  DUR_TRIGGER_TICKS_RST = 8'd1;

  // cm = floor(h * 17 / 500) with h = count / 2, clipped at the field maximum
  localparam logic [31:0] DUR_CM_SAT_HALF = 32'd60236;
  localparam int          DUR_CM_X_W      = 20;
  localparam int          DUR_CM_MULT_W   = 21;
  localparam logic [DUR_CM_MULT_W-1:0] DUR_CM_MULT = 21'd1073742;
  localparam int          DUR_CM_SHIFT    = 29;
  localparam int          DUR_CM_PROD_W   = DUR_CM_X_W + DUR_CM_MULT_W;
  localparam logic [DUR_DIST_W-1:0] DUR_DIST_MAX = 11'd2047;

endpackage

### design/dur_cm.sv
// ----------------------------------------------------------------------------
// dur_cm
// Converts a stored echo count into centimeters: floor(floor(count/2)*34/1000),
// clipped at the width of the distance field. Division by a reciprocal product.
// ----------------------------------------------------------------------------
module dur_cm #(
  parameter int COUNT_WIDTH = dur_pkg::DUR_COUNT_WIDTH
) (
  input  logic [COUNT_WIDTH-1:0]         count,
  output logic [dur_pkg::DUR_DIST_W-1:0] distance_cm
);
  import dur_pkg::*;

  logic [31:0]              half_wide;
  logic [15:0]              half16;
  logic [DUR_CM_X_W-1:0]    x;
  logic [DUR_CM_PROD_W-1:0] prod;
  logic                     sat;

  assign half_wide = 32'(count[COUNT_WIDTH-1:1]);
  assign sat       = half_wide >= DUR_CM_SAT_HALF;
  assign half16    = half_wide[15:0];
  // h * 17 as shift and add
  assign x         = DUR_CM_X_W'(half16) + (DUR_CM_X_W'(half16) << 4);
  // reciprocal of 500 is exact for x below 2^20, no correction step
  assign prod      = DUR_CM_PROD_W'(x) * DUR_CM_PROD_W'(DUR_CM_MULT);

  assign distance_cm = sat ? DUR_DIST_MAX
                           : prod[DUR_CM_SHIFT+DUR_DIST_W-1:DUR_CM_SHIFT];

endmodule

### design/dual_ultrasonic_echo_ranger.sv
// ----------------------------------------------------------------------------
// dual_ultrasonic_echo_ranger
// Sequencer for two ultrasonic rangers, right and left, ranged in turn. Each
// input word is one timer tick and yields exactly one result word. A word
// passes three register stages (input register, state update, distance
// conversion), the last of which is the output register. One word is taken
// every cycle unless the output stalls; the rate is set by the update of the
// phase, trigger and count registers. A stall on the output holds all
// stages, so in_stall follows out_stall while a result waits. Registers
// are written through cfg_we, cfg_index (0 tick_us, 1 min_count,
// 2 trigger_ticks) and cfg_wdata.
// ----------------------------------------------------------------------------
module dual_ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = dur_pkg::DUR_COUNT_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_pulse,
  input  logic                              in_echo_right,
  input  logic                              in_echo_left,
  input  logic                              in_query_channel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_trigger_right,
  output logic                              out_trigger_left,
  output logic [dur_pkg::DUR_DIST_W-1:0]    out_distance_cm,
  output logic                              out_active_channel,
  output logic                              out_new_reading,
  input  logic                              cfg_we,
  input  logic [dur_pkg::DUR_CFG_IDX_W-1:0] cfg_index,
  input  logic [dur_pkg::DUR_CFG_DATA_W-1:0] cfg_wdata
);
  import dur_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ARMED = 2'd1,
    PH_MEAS  = 2'd2
  } phase_t;

  // configuration
  logic [7:0]  tick_us_r;
  logic [15:0] min_count_r;
  logic [7:0]  trigger_ticks_r;

  // input stage
  logic s1_valid_r;
  logic s1_start_r, s1_echo_right_r, s1_echo_left_r, s1_query_r;

  // sequencer state
  phase_t                 phase_r, phase_nxt;
  logic                   channel_r, channel_nxt;
  logic [7:0]             trig_r, trig_nxt;
  logic [COUNT_WIDTH-1:0] running_r, running_nxt;
  logic [COUNT_WIDTH-1:0] right_count_r, right_count_nxt;
  logic [COUNT_WIDTH-1:0] left_count_r, left_count_nxt;
  logic [1:0]             prev_echo_r;

  // update stage
  logic                   s2_valid_r;
  logic                   s2_trig_right_r, s2_trig_left_r, s2_active_r, s2_stored_r;
  logic [COUNT_WIDTH-1:0] s2_count_r;

  // output register
  logic                   out_valid_r;
  logic                   out_trig_right_r, out_trig_left_r, out_active_r, out_stored_r;
  logic [DUR_DIST_W-1:0]  out_dist_r;
  logic [DUR_DIST_W-1:0]  dist_cm;

  logic                   advance;
  logic                   step;
  logic [1:0]             echo;
  logic                   level, rise;
  logic                   stored;
  logic [COUNT_WIDTH:0]   sum;
  logic [COUNT_WIDTH-1:0] sat_count;
  logic [COUNT_WIDTH-1:0] query_count;

  assign advance  = !(out_valid_r && out_stall);
  assign in_stall = !advance;
  assign step     = s1_valid_r && advance;

  assign echo  = {s1_echo_left_r, s1_echo_right_r};
  assign level = echo[channel_r];
  assign rise  = level && !prev_echo_r[channel_r];
  assign sum   = {1'b0, running_r} + (COUNT_WIDTH+1)'(tick_us_r);
  assign sat_count = sum[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : sum[COUNT_WIDTH-1:0];

  always_comb begin
    phase_nxt       = phase_r;
    channel_nxt     = channel_r;
    trig_nxt        = (trig_r != 8'd0) ? trig_r - 8'd1 : 8'd0;
    running_nxt     = running_r;
    right_count_nxt = right_count_r;
    left_count_nxt  = left_count_r;
    stored          = 1'b0;
    case (phase_r)
      PH_MEAS: begin
        running_nxt = sat_count;
        if (!level) begin
          if (CMP_W'(sat_count) > CMP_W'(min_count_r)) begin
            stored = 1'b1;
            if (channel_r) begin
              left_count_nxt = sat_count;
            end else begin
              right_count_nxt = sat_count;
            end
          end
          running_nxt = '0;
          channel_nxt = !channel_r;
          phase_nxt   = PH_IDLE;
          trig_nxt    = 8'd0;
        end
      end
      PH_ARMED: begin
        if (s1_start_r) begin
          trig_nxt = trigger_ticks_r;
        end else if (rise) begin
          running_nxt = '0;
          phase_nxt   = PH_MEAS;
        end
      end
      default: begin
        // idle and the unused code
        if (s1_start_r) begin
          trig_nxt  = trigger_ticks_r;
          phase_nxt = PH_ARMED;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    endcase
    query_count = s1_query_r ? left_count_nxt : right_count_nxt;
  end

  dur_cm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_cm (
    .count       (s2_count_r),
    .distance_cm (dist_cm)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_us_r       <= DUR_TICK_US_RST;
      min_count_r     <= DUR_MIN_COUNT_RST;
      trigger_ticks_r <= DUR_TRIGGER_TICKS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        DUR_CFG_TICK_US:       tick_us_r       <= cfg_wdata[7:0];
        DUR_CFG_MIN_COUNT:     min_count_r     <= cfg_wdata[15:0];
        DUR_CFG_TRIGGER_TICKS: trigger_ticks_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // pipeline control and sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      s2_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_IDLE;
      channel_r     <= 1'b0;
      trig_r        <= 8'd0;
      running_r     <= '0;
      right_count_r <= '0;
      left_count_r  <= '0;
      prev_echo_r   <= 2'b00;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
      if (s1_valid_r) begin
        phase_r       <= phase_nxt;
        channel_r     <= channel_nxt;
        trig_r        <= trig_nxt;
        running_r     <= running_nxt;
        right_count_r <= right_count_nxt;
        left_count_r  <= left_count_nxt;
        prev_echo_r   <= echo;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_start_r       <= in_start_pulse;
      s1_echo_right_r  <= in_echo_right;
      s1_echo_left_r   <= in_echo_left;
      s1_query_r       <= in_query_channel;
      s2_trig_right_r  <= (trig_nxt != 8'd0) && !channel_nxt;
      s2_trig_left_r   <= (trig_nxt != 8'd0) && channel_nxt;
      s2_active_r      <= channel_nxt;
      s2_stored_r      <= stored;
      s2_count_r       <= query_count;
      out_trig_right_r <= s2_trig_right_r;
      out_trig_left_r  <= s2_trig_left_r;
      out_active_r     <= s2_active_r;
      out_stored_r     <= s2_stored_r;
      out_dist_r       <= dist_cm;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_trigger_right  = out_trig_right_r;
  assign out_trigger_left   = out_trig_left_r;
  assign out_distance_cm    = out_dist_r;
  assign out_active_channel = out_active_r;
  assign out_new_reading    = out_stored_r;

  a_store_only_from_meas: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r != PH_MEAS) |=> !s2_stored_r)
    else $error("reading stored outside a measurement");

  a_channel_switch: assert property (@(posedge clk) disable iff (!rst_n)
    (step && phase_r == PH_MEAS && !level) |=> (channel_r != $past(channel_r)))
    else $error("channel did not switch at echo end");

  a_running_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_MEAS) |-> (running_r == '0))
    else $error("running count not clear outside a measurement");

  a_one_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> !(s2_trig_right_r && s2_trig_left_r))
    else $error("both triggers driven");

endmodule
